>>> hdl/tmt_pkg.sv
`default_nettype none
package tmt_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int SLOT_COUNT  = 10;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int COUNT_WRAP  = 11;
    localparam int CNT_W       = $clog2(COUNT_WRAP + 1);
    localparam int SUM_W       = SAMPLE_BITS + $clog2(SLOT_COUNT);
    localparam int AVG_SHIFT   = 3;
    localparam int LEVEL_W     = 12;
    localparam int MODE_W      = 2;
    localparam int MODE_COUNT  = 3;
    localparam int MSEL_W      = $clog2(MODE_COUNT);
    localparam int REG_COUNT   = 8;
    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int ADDR_W      = REG_IDX_W + 2;
    localparam int DATA_W      = 32;

    localparam logic [REG_IDX_W-1:0] REG_HEAT_MODE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOW_LEVEL_0  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_LEVEL_0 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOW_LEVEL_1  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_LEVEL_1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LOW_LEVEL_2  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_LEVEL_2 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_FAULT_LEVEL  = 3'd7;

    localparam logic [MODE_W-1:0]  RST_HEAT_MODE    = 2'd0;
    localparam logic [LEVEL_W-1:0] RST_LOW_LEVEL_0  = 12'd1391;
    localparam logic [LEVEL_W-1:0] RST_HIGH_LEVEL_0 = 12'd1468;
    localparam logic [LEVEL_W-1:0] RST_LOW_LEVEL_1  = 12'd1584;
    localparam logic [LEVEL_W-1:0] RST_HIGH_LEVEL_1 = 12'd1661;
    localparam logic [LEVEL_W-1:0] RST_LOW_LEVEL_2  = 12'd1793;
    localparam logic [LEVEL_W-1:0] RST_HIGH_LEVEL_2 = 12'd1923;
    localparam logic [LEVEL_W-1:0] RST_FAULT_LEVEL  = 12'd500;

    localparam logic [MSEL_W-1:0] MODE_LAST = MSEL_W'(MODE_COUNT - 1);

    typedef struct packed {
        logic [MODE_W-1:0]                    heat_mode;
        logic [MODE_COUNT-1:0][LEVEL_W-1:0]   low_level;
        logic [MODE_COUNT-1:0][LEVEL_W-1:0]   high_level;
        logic [LEVEL_W-1:0]                   fault_level;
    } cfg_t;

    typedef struct packed {
        logic              store_we;
        logic [SLOT_W-1:0] store_slot;
        logic              scan_en;
        logic              scan_first;
        logic [SLOT_W-1:0] scan_idx;
        logic              finish;
        logic              load_out;
        logic              decision;
    } cmd_t;

endpackage
`default_nettype wire

>>> hdl/tmt_regs.sv
`default_nettype none
module tmt_regs
    import tmt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_HEAT_MODE:    cfg_next.heat_mode     = pwdata[MODE_W-1:0];
                REG_LOW_LEVEL_0:  cfg_next.low_level[0]  = pwdata[LEVEL_W-1:0];
                REG_HIGH_LEVEL_0: cfg_next.high_level[0] = pwdata[LEVEL_W-1:0];
                REG_LOW_LEVEL_1:  cfg_next.low_level[1]  = pwdata[LEVEL_W-1:0];
                REG_HIGH_LEVEL_1: cfg_next.high_level[1] = pwdata[LEVEL_W-1:0];
                REG_LOW_LEVEL_2:  cfg_next.low_level[2]  = pwdata[LEVEL_W-1:0];
                REG_HIGH_LEVEL_2: cfg_next.high_level[2] = pwdata[LEVEL_W-1:0];
                REG_FAULT_LEVEL:  cfg_next.fault_level   = pwdata[LEVEL_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_HEAT_MODE:    prdata = DATA_W'(cfg_reg.heat_mode);
            REG_LOW_LEVEL_0:  prdata = DATA_W'(cfg_reg.low_level[0]);
            REG_HIGH_LEVEL_0: prdata = DATA_W'(cfg_reg.high_level[0]);
            REG_LOW_LEVEL_1:  prdata = DATA_W'(cfg_reg.low_level[1]);
            REG_HIGH_LEVEL_1: prdata = DATA_W'(cfg_reg.high_level[1]);
            REG_LOW_LEVEL_2:  prdata = DATA_W'(cfg_reg.low_level[2]);
            REG_HIGH_LEVEL_2: prdata = DATA_W'(cfg_reg.high_level[2]);
            REG_FAULT_LEVEL:  prdata = DATA_W'(cfg_reg.fault_level);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heat_mode     <= RST_HEAT_MODE;
            cfg_reg.low_level[0]  <= RST_LOW_LEVEL_0;
            cfg_reg.high_level[0] <= RST_HIGH_LEVEL_0;
            cfg_reg.low_level[1]  <= RST_LOW_LEVEL_1;
            cfg_reg.high_level[1] <= RST_HIGH_LEVEL_1;
            cfg_reg.low_level[2]  <= RST_LOW_LEVEL_2;
            cfg_reg.high_level[2] <= RST_HIGH_LEVEL_2;
            cfg_reg.fault_level   <= RST_FAULT_LEVEL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/tmt_dp.sv
`default_nettype none
module tmt_dp
    import tmt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    input  wire cfg_t               cfg,
    input  wire logic [LEVEL_W-1:0] adc_sample,
    input  wire logic               detect_enabled,
    output logic                    decision_valid,
    output logic      [LEVEL_W-1:0] average,
    output logic                    heat_enable,
    output logic                    sensor_fault
);

    logic [SAMPLE_BITS-1:0] store_mem [0:SLOT_COUNT-1];
    logic [SAMPLE_BITS-1:0] rd_reg;
    logic                   scan_en_reg;
    logic                   scan_first_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [SAMPLE_BITS-1:0] lo_reg;
    logic [SAMPLE_BITS-1:0] lo_next;
    logic [SAMPLE_BITS-1:0] hi_reg;
    logic [SAMPLE_BITS-1:0] hi_next;
    logic                   detect_reg;
    logic [LEVEL_W-1:0]     average_reg;
    logic [LEVEL_W-1:0]     average_next;
    logic                   heat_reg;
    logic                   heat_next;
    logic                   fault_reg;
    logic                   fault_next;
    logic                   dec_reg;
    logic [SUM_W-1:0]       trim;
    logic [MSEL_W-1:0]      mode_sel;
    logic [LEVEL_W-1:0]     low_sel;
    logic [LEVEL_W-1:0]     high_sel;

    always_ff @(posedge clk)
    begin
        if (cmd.store_we)
        begin
            store_mem[cmd.store_slot] <= adc_sample[SAMPLE_BITS-1:0];
        end
        rd_reg <= store_mem[cmd.scan_idx];
    end

    // running sum, min and max over the slots, one slot per cycle
    always_comb
    begin
        sum_next = sum_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        if (scan_en_reg)
        begin
            if (scan_first_reg)
            begin
                sum_next = SUM_W'(rd_reg);
                lo_next  = rd_reg;
                hi_next  = rd_reg;
            end
            else
            begin
                sum_next = sum_reg + SUM_W'(rd_reg);
                if (rd_reg < lo_reg)
                begin
                    lo_next = rd_reg;
                end
                if (rd_reg > hi_reg)
                begin
                    hi_next = rd_reg;
                end
            end
        end
    end

    assign trim     = sum_reg - SUM_W'(lo_reg) - SUM_W'(hi_reg);
    assign mode_sel = (cfg.heat_mode > MODE_W'(MODE_LAST)) ? MODE_LAST
                                                           : MSEL_W'(cfg.heat_mode);
    assign low_sel  = cfg.low_level[mode_sel];
    assign high_sel = cfg.high_level[mode_sel];

    always_comb
    begin
        average_next = average_reg;
        heat_next    = heat_reg;
        fault_next   = fault_reg;
        if (cmd.finish)
        begin
            average_next = LEVEL_W'(trim >> AVG_SHIFT);
            // clear first, then set: set wins when the levels cross
            if (average_next > high_sel)
            begin
                heat_next = 1'b0;
            end
            if (average_next < low_sel)
            begin
                heat_next = 1'b1;
            end
            if (detect_reg && (average_next < cfg.fault_level))
            begin
                fault_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        if (cmd.store_we)
        begin
            detect_reg <= detect_enabled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_en_reg    <= 1'b0;
            scan_first_reg <= 1'b0;
            average_reg    <= '0;
            heat_reg       <= 1'b0;
            fault_reg      <= 1'b0;
            dec_reg        <= 1'b0;
        end
        else
        begin
            scan_en_reg    <= cmd.scan_en;
            scan_first_reg <= cmd.scan_first;
            average_reg    <= average_next;
            heat_reg       <= heat_next;
            fault_reg      <= fault_next;
            if (cmd.load_out)
            begin
                dec_reg <= cmd.decision;
            end
        end
    end

    assign decision_valid = dec_reg;
    assign average        = average_reg;
    assign heat_enable    = heat_reg;
    assign sensor_fault   = fault_reg;

endmodule
`default_nettype wire

>>> hdl/tmt_ctrl.sv
`default_nettype none
module tmt_ctrl
    import tmt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FIN   = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              accept;
    logic              last_sample;
    logic [SLOT_W-1:0] slot;

    assign in_ready    = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept      = in_valid && in_ready;
    assign last_sample = (count_reg == CNT_W'(COUNT_WRAP));
    assign slot        = (count_reg < CNT_W'(SLOT_COUNT))
                         ? SLOT_W'(count_reg)
                         : SLOT_W'(count_reg - CNT_W'(SLOT_COUNT));
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.store_slot = slot;
        cmd.scan_idx   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.store_we = 1'b1;
                    if (last_sample)
                    begin
                        count_next = '0;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        count_next     = count_reg + CNT_W'(1);
                        cmd.load_out   = 1'b1;
                        cmd.decision   = 1'b0;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en    = 1'b1;
                cmd.scan_first = (idx_reg == '0);
                if (idx_reg == SLOT_W'(SLOT_COUNT - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            // last slot is still in the read register
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.finish     = 1'b1;
                cmd.load_out   = 1'b1;
                cmd.decision   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(COUNT_WRAP))
        else $error("sample counter out of range");

    a_last_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_sample) |=> (state_reg == ST_SCAN) && (idx_reg == '0))
        else $error("twelfth item did not start a scan");

    a_plain_item_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !last_sample) |=> out_valid_reg
                                     && (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("plain item did not post a result");

    a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DRAIN || state_reg == ST_FIN)
        |-> !out_valid_reg)
        else $error("result pending during a scan");

    a_scan_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("scan did not end in a result");

endmodule
`default_nettype wire

>>> hdl/trimmed_mean_thermostat.sv
// trimmed-mean hysteresis thermostat, one result per item
// the first eleven items of a block post their result in the cycle after acceptance;
// the twelfth reads each stored slot, drains the last one and decides while input waits
// throughput: one item per cycle while no decision runs and no result waits on out_ready
// reset: rst_n asynchronous active low; clears counter, flags, average and config
// registers to defaults; the ten-slot sample store is not cleared
`default_nettype none
module trimmed_mean_thermostat
    import tmt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [LEVEL_W-1:0] adc_sample,
    input  wire logic               detect_enabled,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    decision_valid,
    output logic      [LEVEL_W-1:0] average,
    output logic                    heat_enable,
    output logic                    sensor_fault
);

    cfg_t cfg;
    cmd_t cmd;

    tmt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    tmt_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg),
        .adc_sample     (adc_sample),
        .detect_enabled (detect_enabled),
        .decision_valid (decision_valid),
        .average        (average),
        .heat_enable    (heat_enable),
        .sensor_fault   (sensor_fault)
    );

endmodule
`default_nettype wire

>>> tb/sv/thermostat_checker.sv
module thermostat_checker
    import tmt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [LEVEL_W-1:0] adc_sample,
    input  logic               detect_enabled,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               decision_valid,
    input  logic [LEVEL_W-1:0] average,
    input  logic               heat_enable,
    input  logic               sensor_fault,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               decision;
        logic [LEVEL_W-1:0] avg;
        logic               heat;
        logic               fault;
    } reading_t;

    // shadow copy of the threshold registers
    logic [MODE_W-1:0]  heat_mode_q;
    logic [LEVEL_W-1:0] low_lvl [MODE_COUNT];
    logic [LEVEL_W-1:0] high_lvl [MODE_COUNT];
    logic [LEVEL_W-1:0] fault_lvl;

    logic [CNT_W-1:0]   sample_cnt;
    logic [LEVEL_W-1:0] slot_mem [SLOT_COUNT];
    logic [LEVEL_W-1:0] avg_q;
    logic               heat_q;
    logic               fault_q;

    reading_t expected_q [$];
    int       n_fail = 0;

    function automatic reading_t predict_reading(input logic [LEVEL_W-1:0] smp,
                                                 input logic det);
        logic [SUM_W-1:0]   total;
        logic [LEVEL_W-1:0] lo;
        logic [LEVEL_W-1:0] hi;
        logic [MSEL_W-1:0]  msel;
        logic [CNT_W-1:0]   slot;
        reading_t           r;
        slot = (sample_cnt < CNT_W'(SLOT_COUNT)) ? sample_cnt
                                                 : sample_cnt - CNT_W'(SLOT_COUNT);
        slot_mem[slot] = smp & LEVEL_W'((1 << SAMPLE_BITS) - 1);
        r.decision = (sample_cnt == CNT_W'(COUNT_WRAP));
        if (r.decision) begin
            sample_cnt = '0;
            total = SUM_W'(slot_mem[0]);
            lo = slot_mem[0];
            hi = slot_mem[0];
            for (int j = 1; j < SLOT_COUNT; j++) begin
                if (slot_mem[j] < lo) lo = slot_mem[j];
                if (slot_mem[j] > hi) hi = slot_mem[j];
                total = total + SUM_W'(slot_mem[j]);
            end
            total = total - SUM_W'(lo) - SUM_W'(hi);
            avg_q = LEVEL_W'(total >> AVG_SHIFT);
            // the spare mode code falls back to the last threshold pair
            msel = (heat_mode_q > MODE_LAST) ? MODE_LAST : MSEL_W'(heat_mode_q);
            // clear first, then set: with an inverted pair, an average between the levels turns heat on
            if (avg_q > high_lvl[msel]) heat_q = 1'b0;
            if (avg_q < low_lvl[msel]) heat_q = 1'b1;
            if (avg_q < fault_lvl && det) fault_q = 1'b1;
        end
        else begin
            sample_cnt = sample_cnt + 1'b1;
        end
        r.avg   = avg_q;
        r.heat  = heat_q;
        r.fault = fault_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t got;
        reading_t want;
        if (!rst_n)
        begin
            heat_mode_q = RST_HEAT_MODE;
            low_lvl[0]  = RST_LOW_LEVEL_0;
            high_lvl[0] = RST_HIGH_LEVEL_0;
            low_lvl[1]  = RST_LOW_LEVEL_1;
            high_lvl[1] = RST_HIGH_LEVEL_1;
            low_lvl[2]  = RST_LOW_LEVEL_2;
            high_lvl[2] = RST_HIGH_LEVEL_2;
            fault_lvl   = RST_FAULT_LEVEL;
            sample_cnt  = '0;
            avg_q       = '0;
            heat_q      = 1'b0;
            fault_q     = 1'b0;
            expected_q.delete();
            fail_count <= n_fail;
            pending    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_HEAT_MODE:    heat_mode_q = pwdata[MODE_W-1:0];
                    REG_LOW_LEVEL_0:  low_lvl[0]  = pwdata[LEVEL_W-1:0];
                    REG_HIGH_LEVEL_0: high_lvl[0] = pwdata[LEVEL_W-1:0];
                    REG_LOW_LEVEL_1:  low_lvl[1]  = pwdata[LEVEL_W-1:0];
                    REG_HIGH_LEVEL_1: high_lvl[1] = pwdata[LEVEL_W-1:0];
                    REG_LOW_LEVEL_2:  low_lvl[2]  = pwdata[LEVEL_W-1:0];
                    REG_HIGH_LEVEL_2: high_lvl[2] = pwdata[LEVEL_W-1:0];
                    REG_FAULT_LEVEL:  fault_lvl   = pwdata[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = {decision_valid, average, heat_enable, sensor_fault};
                if (expected_q.size() == 0)
                begin
                    $error("result with no item pending: %p", got);
                    n_fail++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.decision !== want.decision)
                    begin
                        $error("decision_valid: expected %0d, got %0d",
                               want.decision, got.decision);
                        n_fail++;
                    end
                    if (got.avg !== want.avg)
                    begin
                        $error("average: expected %0d, got %0d", want.avg, got.avg);
                        n_fail++;
                    end
                    if (got.heat !== want.heat)
                    begin
                        $error("heat_enable: expected %0d, got %0d", want.heat, got.heat);
                        n_fail++;
                    end
                    if (got.fault !== want.fault)
                    begin
                        $error("sensor_fault: expected %0d, got %0d",
                               want.fault, got.fault);
                        n_fail++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(predict_reading(adc_sample, detect_enabled));
            fail_count <= n_fail;
            pending    <= expected_q.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tmt_pkg::*;

    localparam int CYCLE_LIMIT        = 400000;
    localparam int SETTINGS_PER_PHASE = 4;
    localparam int BLOCKS_PER_SETTING = 13;
    localparam int SETTLE_CYCLES      = 16;

    localparam logic [LEVEL_W-1:0] SAMPLE_MAX = LEVEL_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [MODE_W-1:0]  MODE_SPARE = MODE_W'(MODE_COUNT);

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [ADDR_W-1:0]  paddr          = '0;
    logic [DATA_W-1:0]  pwdata         = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid       = 1'b0;
    logic               in_ready;
    logic [LEVEL_W-1:0] adc_sample     = '0;
    logic               detect_enabled = 1'b0;
    logic               out_valid;
    logic               out_ready      = 1'b0;
    logic               decision_valid;
    logic [LEVEL_W-1:0] average;
    logic               heat_enable;
    logic               sensor_fault;

    int fail_count;
    int pending;
    int cycle_count    = 0;
    int feed_gap_pct   = 28;
    int drain_stall_pct = 67;

    trimmed_mean_thermostat u_dut (.*);
    thermostat_checker      u_checker (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    always @(posedge clk) out_ready <= ($urandom_range(99) >= drain_stall_pct);

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic apply_settings(input cfg_t s);
        write_reg(REG_HEAT_MODE,    DATA_W'(s.heat_mode));
        write_reg(REG_LOW_LEVEL_0,  DATA_W'(s.low_level[0]));
        write_reg(REG_HIGH_LEVEL_0, DATA_W'(s.high_level[0]));
        write_reg(REG_LOW_LEVEL_1,  DATA_W'(s.low_level[1]));
        write_reg(REG_HIGH_LEVEL_1, DATA_W'(s.high_level[1]));
        write_reg(REG_LOW_LEVEL_2,  DATA_W'(s.low_level[2]));
        write_reg(REG_HIGH_LEVEL_2, DATA_W'(s.high_level[2]));
        write_reg(REG_FAULT_LEVEL,  DATA_W'(s.fault_level));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(7))
            0:       return '0;
            1:       return SAMPLE_MAX;
            default: return LEVEL_W'($urandom_range(SAMPLE_MAX));
        endcase
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        s.heat_mode = MODE_W'($urandom_range((1 << MODE_W) - 1));
        for (int m = 0; m < MODE_COUNT; m++)
        begin
            s.low_level[m]  = pick_level();
            s.high_level[m] = pick_level();
        end
        s.fault_level = pick_level();
        return s;
    endfunction

    task automatic send_sample(input logic [LEVEL_W-1:0] smp, input logic det);
        while ($urandom_range(99) < feed_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        adc_sample     <= smp;
        detect_enabled <= det;
        do @(posedge clk); while (!in_ready);
    endtask

    // twelve samples clustered around one level, now and then pure noise
    task automatic send_block();
        int center;
        int noisy;
        int v;
        center = $urandom_range(SAMPLE_MAX);
        noisy  = ($urandom_range(9) == 0);
        for (int i = 0; i <= COUNT_WRAP; i++)
        begin
            if (noisy || $urandom_range(9) == 0)
                v = $urandom_range(SAMPLE_MAX);
            else
                v = center + int'($urandom_range(128)) - 64;
            if (v < 0)
                v = 0;
            else if (v > SAMPLE_MAX)
                v = SAMPLE_MAX;
            send_sample(LEVEL_W'(v), $urandom_range(3) == 0);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin
        cfg_t s;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // spare mode code with an inverted pair: average sits between the levels
        s.heat_mode     = MODE_SPARE;
        s.low_level[0]  = RST_LOW_LEVEL_0;
        s.high_level[0] = RST_HIGH_LEVEL_0;
        s.low_level[1]  = RST_LOW_LEVEL_1;
        s.high_level[1] = RST_HIGH_LEVEL_1;
        s.low_level[2]  = 12'd3000;
        s.high_level[2] = 12'd1000;
        s.fault_level   = RST_FAULT_LEVEL;
        apply_settings(s);
        // extremes land in the first two slots, then wrap-around overwrites them
        send_sample('0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        repeat (SLOT_COUNT - 2) send_sample(12'd2000, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample('0, 1'b1);
        wait_idle();

        // full-scale average against a full-scale fault level: no fault
        s.heat_mode     = RST_HEAT_MODE;
        s.low_level[2]  = RST_LOW_LEVEL_2;
        s.high_level[2] = RST_HIGH_LEVEL_2;
        s.fault_level   = SAMPLE_MAX;
        apply_settings(s);
        for (int i = 0; i < COUNT_WRAP; i++)
            send_sample(SAMPLE_MAX, i[0]);
        send_sample('0, 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    feed_gap_pct    = 28;
                    drain_stall_pct = 67;
                end
                1:
                begin
                    feed_gap_pct    = 67;
                    drain_stall_pct = 28;
                end
                default:
                begin
                    feed_gap_pct    = 0;
                    drain_stall_pct = 0;
                end
            endcase
            for (int k = 0; k < SETTINGS_PER_PHASE; k++)
            begin
                wait_idle();
                apply_settings(random_settings());
                repeat (BLOCKS_PER_SETTING) send_block();
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** trimmed_mean_thermostat: PASSED **");
        else
            $display("** trimmed_mean_thermostat: FAILED **");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** trimmed_mean_thermostat: FAILED **");
        $finish;
    end

endmodule
